@@ src/assert_macros.svh @@
// assertion macros shared by the telegram extractor modules
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked once reset is released
`define OKF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// same-cycle implication
`define OKF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OKF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/okf_pkg.sv @@
// shared constants, types and table functions of the telegram field extractor
// no dependencies
`default_nettype none

package okf_pkg;

    localparam int NUM_KEYS_DEF    = 23;
    localparam int MAX_KEY_LEN_DEF = 12;
    localparam int FRAC_DIGITS_DEF = 3;
    localparam int VALUE_BITS_DEF  = 48;

    localparam int TABLE_SIZE = 23;
    localparam int KEY_STR_W  = 96;
    localparam int Q_DEPTH    = 4;
    localparam logic [4:0] FOUND_MAX = 5'd31;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // identifier text, right-justified in each entry
    localparam logic [KEY_STR_W-1:0] KEY_STR [TABLE_SIZE] = '{
        "1-0:1.8.1", "1-0:1.8.2", "1-0:2.8.1", "1-0:2.8.2", "1-0:1.7.0",
        "1-0:2.7.0", "1-0:32.7.0", "1-0:52.7.0", "1-0:72.7.0", "1-0:31.7.0",
        "1-0:51.7.0", "1-0:71.7.0", "1-0:22.7.0", "1-0:42.7.0", "1-0:62.7.0",
        "1-0:21.7.0", "1-0:41.7.0", "1-0:61.7.0", "0-0:96.14.0", "0-1:24.2.3",
        "0-2:24.2.1", "1-0:1.4.0", "1-0:1.6.0"
    };

    localparam int KEY_LEN [TABLE_SIZE] = '{
        9, 9, 9, 9, 9, 9, 10, 10, 10, 10, 10, 10,
        10, 10, 10, 10, 10, 10, 11, 10, 10, 9, 9
    };

    localparam logic [1:0] KEY_BLOCK [TABLE_SIZE] = '{
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2
    };

    typedef enum logic [2:0] {
        PH_ID,
        PH_SKIP,
        PH_SEEK,
        PH_VSTART,
        PH_VAL,
        PH_VSTOP
    } t_phase;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } t_key_hit;

    function automatic logic [7:0] key_char(input int k, input int p);
        logic [7:0] ch;
        ch = 8'h00;
        if (p >= 0 && p < KEY_LEN[k]) begin
            ch = KEY_STR[k][8*(KEY_LEN[k]-1-p) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [1:0] key_block(input int k);
        logic [1:0] b;
        b = 2'd1;
        if (k >= 0 && k < TABLE_SIZE) begin
            b = KEY_BLOCK[k];
        end
        return b;
    endfunction

    function automatic int pow10(input int k);
        int r;
        r = 1;
        for (int i = 0; i < 3; i++) begin
            if (i < k) begin
                r = r * 10;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/obis_telegram_field_extractor.sv @@
// Telegram field extractor, one byte per item.
// Input channel i_valid/o_ready carries i_char_in and i_telegram_last.
// Output channel o_valid/i_ready carries one result per item: a field
// (o_telegram_done low) or the end marker (o_telegram_done high, with
// o_fields_found). A byte yields zero, one or two results; o_last_of_run
// marks the final one of a byte.
// A byte is registered, parsed from the byte register and its results are
// written into a four-entry queue, from which the first result is presented.
// Throughput is one byte per cycle while the queue has room, as the parse
// between the byte register and the queue is combinational; the queue drains
// one result per cycle while i_ready is high, so a byte with a field and the
// marker needs two pops.
// Reset (synchronous, active low) empties the queue and returns the parser
// to the start of a line with no fields seen.
// When the receiver stalls the queue fills; o_ready drops once fewer than
// two entries are free and the byte register holds its item.
// Uses okf_pkg, okf_key_match, okf_value_unit and okf_out_queue.
`default_nettype none
`include "assert_macros.svh"

module obis_telegram_field_extractor import okf_pkg::*; #(
    parameter int NUM_KEYS    = NUM_KEYS_DEF,
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF,
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_char_in,
    input  logic                         i_telegram_last,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [4:0]                   o_field_index,
    output logic signed [VALUE_BITS-1:0] o_value_milli,
    output logic                         o_telegram_done,
    output logic [4:0]                   o_fields_found,
    output logic                         o_last_of_run
);

    localparam int POS_W  = $clog2(MAX_KEY_LEN + 1);
    localparam int DATA_W = VALUE_BITS + 12;

    // byte register
    logic              r_valid;
    logic [7:0]        r_char;
    logic              r_last;

    // parser state
    t_phase                r_phase, n_phase;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [NUM_KEYS-1:0]   r_cand, n_cand;
    logic [NUM_KEYS-1:0]   r_seen, n_seen;
    logic [4:0]            r_matched, n_matched;
    logic [1:0]            r_blk, n_blk;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [1:0]            r_frac, n_frac;
    logic                  r_neg, n_neg;
    logic                  r_point, n_point;
    logic [4:0]            r_found, n_found;

    logic                  proc, room;
    logic                  eol, is_open, is_term, is_digit, is_dot, is_sign;
    logic                  seen_hit, open_ok, seek_done, num_char, num_val;
    logic [1:0]            blk_inc;
    logic                  fv, mv;
    logic [4:0]            found_inc;
    logic [NUM_KEYS-1:0]   cand_next;
    t_key_hit              hit;
    logic [VALUE_BITS-1:0] acc_next;
    logic signed [VALUE_BITS-1:0] value;
    logic [DATA_W-1:0]     field_word, marker_word, wd0, wd1, q_data;

    assign proc    = r_valid && room;
    assign o_ready = !r_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char_in;
            r_last <= i_telegram_last;
        end
    end

    okf_key_match #(
        .NUM_KEYS    (NUM_KEYS),
        .MAX_KEY_LEN (MAX_KEY_LEN),
        .POS_W       (POS_W)
    ) u_match (
        .i_char      (r_char),
        .i_pos       (r_pos),
        .i_cand      (r_cand),
        .o_cand_next (cand_next),
        .o_hit       (hit)
    );

    okf_value_unit #(
        .FRAC_DIGITS (FRAC_DIGITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_value (
        .i_acc       (r_acc),
        .i_digit     (r_char[3:0]),
        .i_frac_cnt  (r_frac),
        .i_neg       (r_neg),
        .o_acc_next  (acc_next),
        .o_value     (value)
    );

    // byte decode
    always_comb begin
        eol       = (r_char == CH_LF) || (r_char == CH_CR);
        is_open   = (r_char == CH_OPEN);
        is_term   = (r_char == CH_STAR) || (r_char == CH_CLOSE);
        is_digit  = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
        is_dot    = (r_char == CH_DOT);
        is_sign   = (r_char == CH_MINUS) || (r_char == CH_PLUS);
        seen_hit  = |(r_seen & (NUM_KEYS'(1) << hit.idx));
        open_ok   = hit.hit && !seen_hit;
        blk_inc   = r_blk + 2'd1;
        seek_done = (blk_inc >= key_block(int'(r_matched)));
        // a byte that goes through the number parse
        num_char  = !is_term && ((r_phase == PH_VSTART && !is_sign) || r_phase == PH_VAL);
        num_val   = is_digit || (is_dot && !r_point);
        fv        = proc && !eol && is_term && (r_phase == PH_VAL || r_phase == PH_VSTOP);
        mv        = proc && r_last;
        // count including a field closed by this byte, before the telegram clears
        found_inc = (fv && r_found != FOUND_MAX) ? r_found + 5'd1 : r_found;
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (proc) begin
            if (eol) begin
                n_phase = PH_ID;
            end else begin
                unique case (r_phase)
                    PH_ID: begin
                        if (is_open) begin
                            if (!open_ok) begin
                                n_phase = PH_SKIP;
                            end else if (key_block(int'(hit.idx)) <= 2'd1) begin
                                n_phase = PH_VSTART;
                            end else begin
                                n_phase = PH_SEEK;
                            end
                        end
                    end
                    PH_SEEK: begin
                        if (is_open && seek_done) begin
                            n_phase = PH_VSTART;
                        end
                    end
                    PH_VSTART, PH_VAL, PH_VSTOP: begin
                        if (is_term) begin
                            n_phase = PH_SKIP;
                        end else if (r_phase == PH_VSTART && is_sign) begin
                            n_phase = PH_VAL;
                        end else if (num_char) begin
                            n_phase = num_val ? PH_VAL : PH_VSTOP;
                        end
                    end
                    PH_SKIP: begin
                        n_phase = PH_SKIP;
                    end
                    default: begin
                        n_phase = PH_SKIP;
                    end
                endcase
            end
            if (r_last) begin
                n_phase = PH_ID;
            end
        end
    end

    // parser datapath
    always_comb begin
        n_pos     = r_pos;
        n_cand    = r_cand;
        n_seen    = r_seen;
        n_matched = r_matched;
        n_blk     = r_blk;
        n_acc     = r_acc;
        n_frac    = r_frac;
        n_neg     = r_neg;
        n_point   = r_point;
        n_found   = r_found;
        if (proc && !eol) begin
            priority case (1'b1)
                r_phase == PH_ID && is_open: begin
                    if (open_ok) begin
                        n_matched = hit.idx;
                        n_blk     = 2'd1;
                        n_acc     = '0;
                        n_frac    = '0;
                        n_neg     = 1'b0;
                        n_point   = 1'b0;
                    end
                end
                r_phase == PH_ID: begin
                    n_cand = cand_next;
                    if (r_pos < POS_W'(MAX_KEY_LEN)) begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
                r_phase == PH_SEEK && is_open: begin
                    n_blk = blk_inc;
                    if (seek_done) begin
                        n_acc   = '0;
                        n_frac  = '0;
                        n_neg   = 1'b0;
                        n_point = 1'b0;
                    end
                end
                fv: begin
                    n_seen = r_seen | (NUM_KEYS'(1) << r_matched);
                    if (r_found != FOUND_MAX) begin
                        n_found = r_found + 5'd1;
                    end
                end
                r_phase == PH_VSTART && r_char == CH_MINUS: begin
                    n_neg = 1'b1;
                end
                num_char && is_digit: begin
                    if (!r_point) begin
                        n_acc = acc_next;
                    end else if (int'(r_frac) < FRAC_DIGITS) begin
                        n_acc  = acc_next;
                        n_frac = r_frac + 2'd1;
                    end
                end
                num_char && is_dot && !r_point: begin
                    n_point = 1'b1;
                end
                default: begin
                end
            endcase
        end
        // line start, also at the end of the telegram
        if (proc && (eol || r_last)) begin
            n_pos     = '0;
            n_cand    = '1;
            n_matched = '0;
            n_blk     = '0;
            n_acc     = '0;
            n_frac    = '0;
            n_neg     = 1'b0;
            n_point   = 1'b0;
        end
        if (proc && r_last) begin
            n_seen  = '0;
            n_found = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ID;
            r_pos     <= '0;
            r_cand    <= '1;
            r_seen    <= '0;
            r_matched <= '0;
            r_blk     <= '0;
            r_acc     <= '0;
            r_frac    <= '0;
            r_neg     <= 1'b0;
            r_point   <= 1'b0;
            r_found   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_cand    <= n_cand;
            r_seen    <= n_seen;
            r_matched <= n_matched;
            r_blk     <= n_blk;
            r_acc     <= n_acc;
            r_frac    <= n_frac;
            r_neg     <= n_neg;
            r_point   <= n_point;
            r_found   <= n_found;
        end
    end

    // result words: field first, marker second when a byte gives both
    always_comb begin
        field_word  = {r_matched, value, 1'b0, 5'd0, !r_last};
        marker_word = {5'd0, {VALUE_BITS{1'b0}}, 1'b1, found_inc, 1'b1};
        wd0         = fv ? field_word : marker_word;
        wd1         = marker_word;
    end

    okf_out_queue #(
        .DATA_W  (DATA_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we0   (fv || mv),
        .i_we1   (fv && mv),
        .i_wd0   (wd0),
        .i_wd1   (wd1),
        .i_pop   (i_ready),
        .o_room  (room),
        .o_valid (o_valid),
        .o_data  (q_data)
    );

    assign o_field_index   = q_data[DATA_W-1 -: 5];
    assign o_value_milli   = signed'(q_data[VALUE_BITS+6:7]);
    assign o_telegram_done = q_data[6];
    assign o_fields_found  = q_data[5:1];
    assign o_last_of_run   = q_data[0];

    `OKF_ASSERT_IMPL(a_field_from_value, fv, r_phase == PH_VAL || r_phase == PH_VSTOP, "field result outside a value")
    `OKF_ASSERT_NEXT(a_telegram_clear, proc && r_last, r_seen == '0 && r_found == '0, "telegram state not cleared")
    `OKF_ASSERT_IMPL(a_seek_block, r_phase == PH_SEEK, r_blk != 2'd0, "block count lost while seeking")

endmodule

`default_nettype wire

@@ src/okf_key_match.sv @@
// identifier matcher: compares one byte against every table entry at the
// current position and finds a complete match; uses okf_pkg
`default_nettype none

module okf_key_match import okf_pkg::*; #(
    parameter int NUM_KEYS    = NUM_KEYS_DEF,
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF,
    parameter int POS_W       = $clog2(MAX_KEY_LEN_DEF + 1)
) (
    input  logic [7:0]          i_char,
    input  logic [POS_W-1:0]    i_pos,
    input  logic [NUM_KEYS-1:0] i_cand,
    output logic [NUM_KEYS-1:0] o_cand_next,
    output t_key_hit            o_hit
);

    localparam int KEY_COUNT = (NUM_KEYS < TABLE_SIZE) ? NUM_KEYS : TABLE_SIZE;

    always_comb begin
        o_cand_next = i_cand;
        if (i_pos >= POS_W'(MAX_KEY_LEN)) begin
            o_cand_next = '0;
        end else begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                if (int'(i_pos) >= KEY_LEN[k] || key_char(k, int'(i_pos)) != i_char) begin
                    o_cand_next[k] = 1'b0;
                end
            end
        end
    end

    // lowest matching entry wins, scanned from the top down
    always_comb begin
        o_hit = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--) begin
            if (i_cand[k] && int'(i_pos) == KEY_LEN[k] &&
                i_pos <= POS_W'(MAX_KEY_LEN)) begin
                o_hit.hit = 1'b1;
                o_hit.idx = 5'(k);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/okf_value_unit.sv @@
// decimal value arithmetic: saturating multiply-by-ten accumulate and the
// final scaling, sign and saturation; uses okf_pkg
`default_nettype none

module okf_value_unit import okf_pkg::*; #(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  logic [VALUE_BITS-1:0]        i_acc,
    input  logic [3:0]                   i_digit,
    input  logic [1:0]                   i_frac_cnt,
    input  logic                         i_neg,
    output logic [VALUE_BITS-1:0]        o_acc_next,
    output logic signed [VALUE_BITS-1:0] o_value
);

    localparam int MW = VALUE_BITS + 4;
    localparam int SW = VALUE_BITS + 10;
    localparam logic [VALUE_BITS-1:0] MAG_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    logic [MW-1:0]         wide10;
    logic [SW-1:0]         scale;
    logic [SW-1:0]         prod;
    logic [VALUE_BITS-1:0] mag;

    // accumulator never exceeds the magnitude limit, so ten times it fits
    assign wide10     = {4'b0, i_acc} * MW'(10) + MW'(i_digit);
    assign o_acc_next = (wide10 > {4'b0, MAG_MAX}) ? MAG_MAX : wide10[VALUE_BITS-1:0];

    // missing fraction digits: one scale by 10^k, saturation is the same
    assign scale = SW'(pow10(FRAC_DIGITS - int'(i_frac_cnt)));
    assign prod  = {10'b0, i_acc} * scale;
    assign mag   = (prod > {10'b0, MAG_MAX}) ? MAG_MAX : prod[VALUE_BITS-1:0];

    assign o_value = i_neg ? signed'(-mag) : signed'(mag);

endmodule

`default_nettype wire

@@ src/okf_out_queue.sv @@
// small result queue, up to two writes and one read per cycle
// uses okf_pkg for its depth
`default_nettype none
`include "assert_macros.svh"

module okf_out_queue import okf_pkg::*; #(
    parameter int DATA_W = 60
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we0,
    input  logic              i_we1,
    input  logic [DATA_W-1:0] i_wd0,
    input  logic [DATA_W-1:0] i_wd1,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign o_room  = (r_count <= CNT_W'(Q_DEPTH - 2));
    assign pop     = o_valid && i_pop;

    always_comb begin
        n_wp    = r_wp + PTR_W'(i_we0) + PTR_W'(i_we1);
        n_rp    = r_rp + PTR_W'(pop);
        n_count = r_count + CNT_W'(i_we0) + CNT_W'(i_we1) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we0) begin
            r_mem[r_wp] <= i_wd0;
        end
        if (i_we1) begin
            r_mem[r_wp + PTR_W'(1)] <= i_wd1;
        end
    end

    `OKF_ASSERT(a_queue_bound, r_count <= CNT_W'(Q_DEPTH), "result queue overflow")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking bench for obis_telegram_field_extractor: random and directed telegrams
// go in byte by byte, every result is checked against a behavioural parser kept here
// depends on okf_pkg (phase enum, character codes, default sizes) and the block itself
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import okf_pkg::*;

    localparam int          VW        = VALUE_BITS_DEF;
    localparam logic [63:0] MAG_LIMIT = (64'd1 << (VALUE_BITS_DEF - 1)) - 64'd1;
    localparam int          HOLD_LEN  = 400;
    localparam int          HOLD_AT   = 300;
    localparam int          CALM_FROM = 1000;
    localparam int          CALM_TO   = 1300;
    localparam int          N_BYTES   = 1600;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       drain;
    } t_byte;

    typedef struct {
        logic [4:0]           idx;
        logic signed [VW-1:0] value;
        logic                 done;
        logic [4:0]           found;
        logic                 last;
    } t_result;

    // identifier table and wanted block number, in table order
    string obis_id [NUM_KEYS_DEF] = '{
        "1-0:1.8.1", "1-0:1.8.2", "1-0:2.8.1", "1-0:2.8.2", "1-0:1.7.0",
        "1-0:2.7.0", "1-0:32.7.0", "1-0:52.7.0", "1-0:72.7.0", "1-0:31.7.0",
        "1-0:51.7.0", "1-0:71.7.0", "1-0:22.7.0", "1-0:42.7.0", "1-0:62.7.0",
        "1-0:21.7.0", "1-0:41.7.0", "1-0:61.7.0", "0-0:96.14.0", "0-1:24.2.3",
        "0-2:24.2.1", "1-0:1.4.0", "1-0:1.6.0"
    };
    int obis_block [NUM_KEYS_DEF] = '{
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 2, 2, 1, 2
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [7:0]           i_char_in = 8'h00;
    logic                 i_telegram_last = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [4:0]           o_field_index;
    logic signed [VW-1:0] o_value_milli;
    logic                 o_telegram_done;
    logic [4:0]           o_fields_found;
    logic                 o_last_of_run;

    t_byte   telegram_bytes [$];
    t_result field_q [$];
    t_byte   next_byte;

    logic in_taken = 1'b0;
    int   bytes_in = 0;
    int   err_count = 0;
    int   fields_checked = 0;
    int   markers_checked = 0;
    int   telegrams = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    bit   drain_next = 1'b0;
    bit   drain_armed = 1'b0;

    // parser copy
    t_phase      ph;
    int unsigned id_pos;
    logic [22:0] cand_keys;
    logic [22:0] seen_keys;
    int unsigned hit_key;
    logic [1:0]  blk_cnt;
    logic [63:0] mag_acc;
    int unsigned frac_cnt;
    bit          is_neg;
    bit          past_point;
    logic [4:0]  found_cnt;

    obis_telegram_field_extractor DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_char_in       (i_char_in),
        .i_telegram_last (i_telegram_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_field_index   (o_field_index),
        .o_value_milli   (o_value_milli),
        .o_telegram_done (o_telegram_done),
        .o_fields_found  (o_fields_found),
        .o_last_of_run   (o_last_of_run)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on result %0d: %s got %0d expected %0d",
                 $realtime, fields_checked + markers_checked, what, got, want);
        err_count++;
    endtask

    // ---------------- parser copy ----------------

    function automatic logic [63:0] scale_add(input logic [63:0] a, input logic [63:0] d);
        if (a > (MAG_LIMIT - d) / 64'd10) begin
            return MAG_LIMIT;
        end
        return a * 64'd10 + d;
    endfunction

    task automatic new_line();
        ph         = PH_ID;
        id_pos     = 0;
        cand_keys  = '1;
        hit_key    = 0;
        blk_cnt    = 2'd0;
        mag_acc    = 64'd0;
        frac_cnt   = 0;
        is_neg     = 1'b0;
        past_point = 1'b0;
    endtask

    task automatic clear_telegram();
        new_line();
        seen_keys = '0;
        found_cnt = 5'd0;
    endtask

    task automatic open_value();
        ph         = PH_VSTART;
        mag_acc    = 64'd0;
        frac_cnt   = 0;
        is_neg     = 1'b0;
        past_point = 1'b0;
    endtask

    task automatic number_byte(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            if (!past_point) begin
                mag_acc = scale_add(mag_acc, 64'(c - CH_ZERO));
            end else if (frac_cnt < FRAC_DIGITS_DEF) begin
                mag_acc = scale_add(mag_acc, 64'(c - CH_ZERO));
                frac_cnt++;
            end
            ph = PH_VAL;
        end else if (c == CH_DOT && !past_point) begin
            past_point = 1'b1;
            ph = PH_VAL;
        end else begin
            ph = PH_VSTOP;
        end
    endtask

    task automatic parse_byte(input logic [7:0] c, input logic last);
        t_result     r;
        t_result     mark;
        bit          got;
        bit          hit;
        int          k_hit;
        logic [63:0] a;
        int unsigned f;
        got   = 1'b0;
        hit   = 1'b0;
        k_hit = 0;
        if (c == CH_LF || c == CH_CR) begin
            new_line();
        end else begin
            case (ph)
                PH_ID: begin
                    if (c == CH_OPEN) begin
                        for (int k = 0; k < NUM_KEYS_DEF; k++) begin
                            if (!hit && cand_keys[k] && obis_id[k].len() == id_pos &&
                                id_pos <= MAX_KEY_LEN_DEF) begin
                                hit   = 1'b1;
                                k_hit = k;
                            end
                        end
                        if (!hit || seen_keys[k_hit]) begin
                            ph = PH_SKIP;
                        end else begin
                            hit_key = k_hit;
                            blk_cnt = 2'd1;
                            if (obis_block[k_hit] <= 1) open_value();
                            else ph = PH_SEEK;
                        end
                    end else if (id_pos >= MAX_KEY_LEN_DEF) begin
                        cand_keys = '0;
                    end else begin
                        for (int k = 0; k < NUM_KEYS_DEF; k++) begin
                            if (id_pos >= obis_id[k].len() || obis_id[k][id_pos] != c) begin
                                cand_keys[k] = 1'b0;
                            end
                        end
                        id_pos++;
                    end
                end
                PH_SEEK: begin
                    if (c == CH_OPEN) begin
                        blk_cnt = blk_cnt + 2'd1;
                        if (blk_cnt >= obis_block[hit_key]) open_value();
                    end
                end
                PH_VSTART, PH_VAL, PH_VSTOP: begin
                    if (c == CH_STAR || c == CH_CLOSE) begin
                        if (ph != PH_VSTART) begin
                            a = mag_acc;
                            f = frac_cnt;
                            while (f < FRAC_DIGITS_DEF) begin
                                a = scale_add(a, 64'd0);
                                f++;
                            end
                            if (is_neg) a = -a;
                            r.idx   = 5'(hit_key);
                            r.value = a[VW-1:0];
                            r.done  = 1'b0;
                            r.found = 5'd0;
                            r.last  = 1'b1;
                            got     = 1'b1;
                            seen_keys[hit_key] = 1'b1;
                            if (found_cnt < FOUND_MAX) found_cnt++;
                        end
                        ph = PH_SKIP;
                    end else if (ph == PH_VSTART) begin
                        if (c == CH_MINUS) begin
                            is_neg = 1'b1;
                            ph = PH_VAL;
                        end else if (c == CH_PLUS) begin
                            ph = PH_VAL;
                        end else begin
                            number_byte(c);
                        end
                    end else if (ph == PH_VAL) begin
                        number_byte(c);
                    end
                end
                default: begin
                end
            endcase
        end
        if (got) begin
            r.last = !last;
            field_q.push_back(r);
        end
        if (last) begin
            mark.idx   = 5'd0;
            mark.value = '0;
            mark.done  = 1'b1;
            mark.found = found_cnt;
            mark.last  = 1'b1;
            field_q.push_back(mark);
            clear_telegram();
        end
    endtask

    // ---------------- telegram builder ----------------

    task automatic push_byte(input logic [7:0] c);
        t_byte b;
        b.ch       = c;
        b.last     = 1'b0;
        b.drain    = drain_next;
        drain_next = 1'b0;
        telegram_bytes.push_back(b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
        end
    endtask

    task automatic push_eol();
        int r;
        r = $urandom_range(9);
        if (r < 6) begin
            push_byte(CH_CR);
            push_byte(CH_LF);
        end else if (r < 9) begin
            push_byte(CH_LF);
        end else begin
            push_byte(CH_CR);
        end
    endtask

    task automatic mark_last();
        telegram_bytes[telegram_bytes.size() - 1].last = 1'b1;
        telegrams++;
    endtask

    task automatic push_digits(input int n);
        repeat (n) push_byte(CH_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic push_number();
        string junk;
        int    sgn;
        junk = "x.-+ 7e";
        sgn  = $urandom_range(3);
        if (sgn == 1) push_byte(CH_MINUS);
        else if (sgn == 2) push_byte(CH_PLUS);
        // now and then enough digits to saturate
        if ($urandom_range(19) == 0) push_digits($urandom_range(20, 14));
        else push_digits($urandom_range(6));
        if ($urandom_range(2) != 0) begin
            push_byte(CH_DOT);
            push_digits($urandom_range(5));
        end
        if ($urandom_range(9) == 0) push_byte(junk[$urandom_range(junk.len() - 1)]);
    endtask

    task automatic push_line(input bit eol);
        int    kind;
        int    k;
        string s;
        kind = $urandom_range(99);
        k    = $urandom_range(NUM_KEYS_DEF - 1);
        s    = obis_id[k];
        if (kind < 62) begin
            push_text(s);
            push_byte(CH_OPEN);
            if (obis_block[k] == 2) push_text("101209113020W)(");
            push_number();
            if ($urandom_range(1) == 1) push_text("*kWh");
            push_byte(CH_CLOSE);
        end else if (kind < 70) begin
            // near miss: one character changed or the tail cut off
            if ($urandom_range(1) == 1) s[$urandom_range(s.len() - 1)] = 8'($urandom_range(33, 126));
            else s = s.substr(0, s.len() - 2);
            push_text(s);
            push_byte(CH_OPEN);
            push_number();
            push_byte(CH_CLOSE);
        end else if (kind < 75) begin
            push_text(s);
            push_digits($urandom_range(1, 6));
            push_text("(1.5)");
        end else if (kind < 80) begin
            push_text(s);
            push_byte(CH_OPEN);
            if (obis_block[k] == 2) push_text("1W)(");
            push_byte(($urandom_range(1) == 1) ? CH_STAR : CH_CLOSE);
        end else if (kind < 85) begin
            push_text(s);
            if (obis_block[k] == 2) push_text("(1W)");
            else push_text(" 12.5");
        end else if (kind < 90) begin
            // value still open when the line ends
            push_text(s);
            push_byte(CH_OPEN);
            push_number();
        end else begin
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(255)));
        end
        if (eol) push_eol();
    endtask

    // ---------------- sender ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (telegram_bytes.size() != 0 &&
                !(telegram_bytes[0].drain && field_q.size() != 0) &&
                ((bytes_in >= CALM_FROM && bytes_in < CALM_TO) || $urandom_range(99) >= 26)) begin
                next_byte = telegram_bytes.pop_front();
                i_char_in       <= next_byte.ch;
                i_telegram_last <= next_byte.last;
                i_valid         <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (!hold_done && bytes_in >= HOLD_AT) begin
                hold_left <= HOLD_LEN;
                hold_done <= 1'b1;
            end
            i_ready <= (hold_left == 0) &&
                       ((bytes_in >= CALM_FROM && bytes_in < CALM_TO) ||
                        $urandom_range(99) >= 26);
        end
    end

    // ---------------- monitor ----------------

    task automatic check_result();
        t_result want;
        if (field_q.size() == 0) begin
            report_mismatch("result with nothing expected, field_index", o_field_index, 0);
            return;
        end
        want = field_q.pop_front();
        if (o_field_index !== want.idx)
            report_mismatch("field_index", o_field_index, want.idx);
        if (o_value_milli !== want.value)
            report_mismatch("value_milli", o_value_milli, want.value);
        if (o_telegram_done !== want.done)
            report_mismatch("telegram_done", o_telegram_done, want.done);
        if (o_fields_found !== want.found)
            report_mismatch("fields_found", o_fields_found, want.found);
        if (o_last_of_run !== want.last)
            report_mismatch("last_of_run", o_last_of_run, want.last);
        if (want.done) markers_checked++;
        else fields_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                parse_byte(i_char_in, i_telegram_last);
                bytes_in <= bytes_in + 1;
            end
            if (o_valid && i_ready) check_result();
        end
    end

    // ---------------- stimulus and end of run ----------------

    initial begin
        int n_lines;
        int finish_kind;
        int guard;
        clear_telegram();

        // directed telegram: sign, truncation, second block, repeat, empty,
        // missing bracket, saturation both ways, overlong and empty identifier,
        // value cut by line end, value left open at the end of the telegram
        push_text("1-0:1.8.1(+12.3456*kWh)");  push_eol();
        push_text("0-1:24.2.3(101209W)(-7.5)"); push_eol();
        push_text("1-0:1.8.1(5)");              push_eol();
        push_text("1-0:2.8.1()");               push_eol();
        push_text("1-0:2.8.2");                 push_eol();
        push_text("1-0:1.7.0(999999999999999999)");      push_eol();
        push_text("1-0:2.7.0(-999999999999999999*kW)");  push_eol();
        push_text("1-0:1.8.1234567(1)");        push_eol();
        push_text("1-0:32.7.0(23");             push_eol();
        push_text("(5)");                       push_eol();
        push_text("0-2:24.2.1(1)");             push_eol();
        push_text("1-0:1.6.0(12)(1.2.3x)");
        mark_last();
        // one-byte telegrams with every bit set and every bit clear
        push_byte(8'hFF);
        mark_last();
        push_byte(8'h00);
        mark_last();
        // text without digits still gives a zero value
        push_text("1-0:1.8.2(.)");    push_eol();
        push_text("1-0:1.4.0(-)");    push_eol();
        push_text("1-0:2.8.2(abc)");  push_eol();
        push_text("!");
        mark_last();

        while (telegram_bytes.size() < N_BYTES) begin
            if (!drain_armed && telegram_bytes.size() >= N_BYTES / 2) begin
                drain_next  = 1'b1;
                drain_armed = 1'b1;
            end
            if ($urandom_range(1) == 1) begin
                push_text("/XMX5LGBBFG1012463034");
                push_eol();
            end
            n_lines     = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            finish_kind = $urandom_range(3);
            for (int i = 0; i < n_lines; i++) begin
                push_line(i != n_lines - 1 || finish_kind != 0);
            end
            if (finish_kind == 1) begin
                push_text("!5A3C");
                push_eol();
            end
            mark_last();
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (telegram_bytes.size() != 0 || i_valid) @(posedge i_clk);
        guard = 0;
        while (field_q.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (field_q.size() != 0) report_mismatch("results never delivered", field_q.size(), 0);

        $display("ran %0d bytes in %0d telegrams; %0d field results and %0d end markers compared",
                 bytes_in, telegrams, fields_checked, markers_checked);
        $display("included a %0d-cycle receiver hold-off, a sender drain pause and %0d mismatches",
                 HOLD_LEN, err_count);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("run timed out with %0d results still expected", field_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
